>>> rtl/sqm2k_pkg.sv
// Package for the square-root-modulo-2^e core.
// Holds the field widths, default parameters and the job descriptor
// passed from the front end to the back end. No dependencies.
package sqm2k_pkg;

  localparam int VALUE_W   = 12;
  localparam int EXP_W     = 4;
  localparam int COUNT_W   = 7;
  localparam int IDX_W     = 6;
  localparam int NB_W      = 3;
  localparam int HALF_W    = 3;
  localparam int NUM_BASE  = 4;

  localparam int MAX_EXP_DEF     = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [NUM_BASE-1:0][VALUE_W-1:0] base;
    logic [NB_W-1:0]                  nb;
    logic [HALF_W-1:0]                half;
    logic [EXP_W-1:0]                 sh;
    logic [COUNT_W-1:0]               count;
  } desc_t;

endpackage

>>> rtl/sqm2k_front.sv
// Front end: accepts an item, classifies it and lifts odd parts bit by bit.
// Emits one root descriptor per item into the job queue.
// Depends on sqm2k_pkg.
module sqm2k_front #(
  parameter int MAX_EXP = sqm2k_pkg::MAX_EXP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [sqm2k_pkg::VALUE_W-1:0]      value,
  input  logic [sqm2k_pkg::EXP_W-1:0]        exponent,
  output logic                               q_push,
  output sqm2k_pkg::desc_t                   q_wdata,
  input  logic                               q_full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIFT,
    ST_PUSH
  } state_t;

  state_t state;

  logic [sqm2k_pkg::EXP_W-1:0]   e_sat;
  logic [sqm2k_pkg::VALUE_W:0]   mask13;
  sqm2k_pkg::value_t             a;
  logic [sqm2k_pkg::EXP_W-1:0]   k;
  sqm2k_pkg::value_t             b;
  logic                          cl_fail;
  logic                          cl_lift;
  logic [sqm2k_pkg::EXP_W-1:0]   cl_ep;
  logic [sqm2k_pkg::HALF_W-1:0]  cl_half;
  logic [sqm2k_pkg::EXP_W-1:0]   cl_sh;
  logic [sqm2k_pkg::NB_W-1:0]    cl_nb;
  sqm2k_pkg::value_t             cl_b0;
  sqm2k_pkg::value_t             cl_b1;

  logic [sqm2k_pkg::EXP_W-1:0]   ep;
  logic [sqm2k_pkg::EXP_W-1:0]   ex;
  sqm2k_pkg::value_t             tgt;
  sqm2k_pkg::value_t             c0;
  sqm2k_pkg::value_t             c1;
  logic                          phase;
  logic                          lifted;
  logic [sqm2k_pkg::NB_W-1:0]    nb;
  logic [sqm2k_pkg::HALF_W-1:0]  half;
  logic [sqm2k_pkg::EXP_W-1:0]   sh;
  logic [sqm2k_pkg::COUNT_W-1:0] count;

  sqm2k_pkg::value_t             pw;
  logic [sqm2k_pkg::VALUE_W:0]   msk13;
  sqm2k_pkg::value_t             sel;
  logic [2*sqm2k_pkg::VALUE_W-1:0] prod;
  logic                          sq_ok;
  logic [sqm2k_pkg::EXP_W-1:0]   ex_next;
  logic [sqm2k_pkg::VALUE_W:0]   p13;

  assign full = (state != ST_IDLE);

  always_comb begin
    if (exponent > sqm2k_pkg::EXP_W'(MAX_EXP)) begin
      e_sat = sqm2k_pkg::EXP_W'(MAX_EXP);
    end else begin
      e_sat = exponent;
    end
    mask13 = ((sqm2k_pkg::VALUE_W+1)'(1) << e_sat) - (sqm2k_pkg::VALUE_W+1)'(1);
    a      = value & mask13[sqm2k_pkg::VALUE_W-1:0];
    k      = '0;
    for (int i = sqm2k_pkg::VALUE_W - 1; i >= 0; i--) begin
      if (a[i]) begin
        k = sqm2k_pkg::EXP_W'(i);
      end
    end
    b = a >> k;

    cl_fail = 1'b0;
    cl_lift = 1'b0;
    cl_ep   = e_sat;
    cl_half = '0;
    cl_sh   = e_sat;
    cl_nb   = sqm2k_pkg::NB_W'(1);
    cl_b0   = '0;
    cl_b1   = '0;
    if (e_sat == sqm2k_pkg::EXP_W'(0)) begin
      cl_b0 = '0;
    end else if (e_sat == sqm2k_pkg::EXP_W'(1)) begin
      cl_b0 = sqm2k_pkg::VALUE_W'(a[0]);
    end else if (e_sat == sqm2k_pkg::EXP_W'(2)) begin
      if (!a[1]) begin
        cl_b0 = sqm2k_pkg::VALUE_W'(a[0]);
        cl_b1 = sqm2k_pkg::VALUE_W'(a[0]) + sqm2k_pkg::VALUE_W'(2);
        cl_nb = sqm2k_pkg::NB_W'(2);
      end else begin
        cl_fail = 1'b1;
      end
    end else if (a[0]) begin
      if (a[2:0] != 3'b001) begin
        cl_fail = 1'b1;
      end else begin
        cl_lift = 1'b1;
        cl_nb   = sqm2k_pkg::NB_W'(4);
      end
    end else if (a == '0) begin
      cl_half = sqm2k_pkg::HALF_W'(e_sat >> 1);
      cl_sh   = e_sat - sqm2k_pkg::EXP_W'(cl_half);
    end else if (k[0]) begin
      cl_fail = 1'b1;
    end else begin
      cl_ep   = e_sat - k;
      cl_half = sqm2k_pkg::HALF_W'(k >> 1);
      cl_sh   = sqm2k_pkg::EXP_W'(cl_half) + cl_ep;
      if (cl_ep == sqm2k_pkg::EXP_W'(1)) begin
        cl_b0 = sqm2k_pkg::VALUE_W'(1);
      end else if (cl_ep == sqm2k_pkg::EXP_W'(2)) begin
        if (!b[1]) begin
          cl_b0 = sqm2k_pkg::VALUE_W'(1);
          cl_b1 = sqm2k_pkg::VALUE_W'(3);
          cl_nb = sqm2k_pkg::NB_W'(2);
        end else begin
          cl_fail = 1'b1;
        end
      end else if (b[2:0] != 3'b001) begin
        cl_fail = 1'b1;
      end else begin
        cl_lift = 1'b1;
        cl_nb   = sqm2k_pkg::NB_W'(4);
      end
    end
  end

  always_comb begin
    pw      = sqm2k_pkg::VALUE_W'(1) << ex;
    msk13   = ((sqm2k_pkg::VALUE_W+1)'(1) << (ex + sqm2k_pkg::EXP_W'(1)))
              - (sqm2k_pkg::VALUE_W+1)'(1);
    sel     = phase ? c1 : c0;
    prod    = sel * sel;
    sq_ok   = ((prod[sqm2k_pkg::VALUE_W-1:0] ^ tgt) & msk13[sqm2k_pkg::VALUE_W-1:0]) == '0;
    ex_next = ex + sqm2k_pkg::EXP_W'(1);
    p13     = (sqm2k_pkg::VALUE_W+1)'(1) << ep;
  end

  always_comb begin
    q_push        = (state == ST_PUSH) && !q_full;
    q_wdata.nb    = nb;
    q_wdata.half  = half;
    q_wdata.sh    = sh;
    q_wdata.count = count;
    if (lifted) begin
      q_wdata.base[0] = c0;
      q_wdata.base[1] = sqm2k_pkg::VALUE_W'(p13 - (sqm2k_pkg::VALUE_W+1)'(c0));
      q_wdata.base[2] = c1;
      q_wdata.base[3] = sqm2k_pkg::VALUE_W'(p13 - (sqm2k_pkg::VALUE_W+1)'(c1));
    end else begin
      q_wdata.base[0] = c0;
      q_wdata.base[1] = c1;
      q_wdata.base[2] = '0;
      q_wdata.base[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            ep     <= cl_ep;
            tgt    <= b;
            nb     <= cl_nb;
            half   <= cl_half;
            sh     <= cl_sh;
            count  <= cl_fail ? '0 : (sqm2k_pkg::COUNT_W'(cl_nb) << cl_half);
            lifted <= cl_lift;
            ex     <= sqm2k_pkg::EXP_W'(3);
            phase  <= 1'b0;
            if (cl_lift) begin
              c0 <= sqm2k_pkg::VALUE_W'(1);
              c1 <= sqm2k_pkg::VALUE_W'(3);
            end else begin
              c0 <= cl_b0;
              c1 <= cl_b1;
            end
            if (cl_lift && cl_ep != sqm2k_pkg::EXP_W'(3)) begin
              state <= ST_LIFT;
            end else begin
              state <= ST_PUSH;
            end
          end
        end
        ST_LIFT: begin
          if (!phase && !sq_ok) begin
            phase <= 1'b1;
          end else begin
            if (!phase) begin
              c1 <= pw - c0;
            end else if (sq_ok) begin
              c0 <= c1;
              c1 <= pw - c1;
            end else begin
              c0 <= pw - c1;
            end
            phase <= 1'b0;
            ex    <= ex_next;
            if (ex_next == ep) begin
              state <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_lift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIFT) |-> (ex < ep))
    else $error("lift step past target exponent");

  a_lift_odd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIFT) |-> (c0[0] && c1[0]))
    else $error("lift candidate lost odd parity");

endmodule

>>> rtl/sqm2k_queue.sv
// Short job queue between front end and back end.
// Register-based FIFO of root descriptors. Depends on sqm2k_pkg.
module sqm2k_queue #(
  parameter int DEPTH = sqm2k_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sqm2k_pkg::desc_t wdata,
  output logic             full,
  input  logic             pop,
  output sqm2k_pkg::desc_t rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sqm2k_pkg::desc_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

>>> rtl/sqm2k_back.sv
// Back end: expands a root descriptor into results, one per cycle while the
// registered result stage it drives is free or popped. Depends on sqm2k_pkg.
module sqm2k_back (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              q_pop,
  input  sqm2k_pkg::desc_t                  q_rdata,
  input  logic                              q_empty,
  output logic                              empty,
  input  logic                              pop,
  output logic [sqm2k_pkg::VALUE_W-1:0]     root,
  output logic                              found,
  output logic [sqm2k_pkg::COUNT_W-1:0]     root_count,
  output logic                              last
);

  sqm2k_pkg::desc_t              d;
  logic                          active;
  logic                          ovalid;
  logic [sqm2k_pkg::IDX_W-1:0]   i;
  logic [1:0]                    j;
  logic [sqm2k_pkg::COUNT_W-1:0] idx;

  logic                          adv;
  logic                          fail;
  logic                          is_last;
  sqm2k_pkg::value_t             cur_root;

  assign empty = !ovalid;
  assign q_pop = !active && !q_empty;
  assign adv   = active && (!ovalid || pop);

  always_comb begin
    fail     = (d.count == '0);
    is_last  = fail || (idx == d.count - sqm2k_pkg::COUNT_W'(1));
    cur_root = (d.base[j] << d.half)
               + (sqm2k_pkg::VALUE_W'(i) << d.sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (adv) begin
        root       <= fail ? '0 : cur_root;
        found      <= !fail;
        root_count <= d.count;
        last       <= is_last;
        ovalid     <= 1'b1;
        idx        <= idx + sqm2k_pkg::COUNT_W'(1);
        if (is_last) begin
          active <= 1'b0;
        end else if ({1'b0, j} == d.nb - sqm2k_pkg::NB_W'(1)) begin
          j <= '0;
          i <= i + sqm2k_pkg::IDX_W'(1);
        end else begin
          j <= j + 2'd1;
        end
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      if (q_pop) begin
        d      <= q_rdata;
        active <= 1'b1;
        i      <= '0;
        j      <= '0;
        idx    <= '0;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (active && d.count != '0) |-> (idx < d.count))
    else $error("root index past count");

  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !found) |-> (last && root == '0 && root_count == '0))
    else $error("malformed not-found result");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    (ovalid && found) |-> (root_count != '0))
    else $error("found result with zero count");

endmodule

>>> rtl/sqrt_mod_power_of_two_core.sv
// Square roots modulo 2^e: front end, job queue and back end.
// The odd-part lift works one bit at a time above the third, one squarer
// shared. Throughput: the back end emits one root per cycle while its
// result stage is free or popped, up to 64 per item. The front end takes
// no new item until the previous item's descriptor is in the queue.
// Reset (rst, synchronous) empties queue and result stage; no clearing pass.
module sqrt_mod_power_of_two_core #(
  parameter int MAX_EXP     = sqm2k_pkg::MAX_EXP_DEF,
  parameter int QUEUE_DEPTH = sqm2k_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [sqm2k_pkg::VALUE_W-1:0]     value,
  input  logic [sqm2k_pkg::EXP_W-1:0]       exponent,
  output logic                              empty,
  input  logic                              pop,
  output logic [sqm2k_pkg::VALUE_W-1:0]     root,
  output logic                              found,
  output logic [sqm2k_pkg::COUNT_W-1:0]     root_count,
  output logic                              last
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  sqm2k_pkg::desc_t q_wdata;
  sqm2k_pkg::desc_t q_rdata;

  sqm2k_front #(
    .MAX_EXP (MAX_EXP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .exponent (exponent),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  sqm2k_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sqm2k_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_pop      (q_pop),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .empty      (empty),
    .pop        (pop),
    .root       (root),
    .found      (found),
    .root_count (root_count),
    .last       (last)
  );

endmodule
